FILE: rtl/lsh_pkg.sv
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared types and constants for the SET/UA link setup block.
// ----------------------------------------------------------------------------
`default_nettype none

package lsh_pkg;

  // frame bytes
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ADDR_SET  = 8'h03;
  localparam logic [7:0] CTRL_SET  = 8'h03;
  localparam logic [7:0] ADDR_UA   = 8'h01;
  localparam logic [7:0] CTRL_UA   = 8'h07;

  // bytes in one supervisory frame
  localparam logic [2:0] FRAME_LEN = 3'd5;

  // register reset values
  localparam logic [15:0] TIMEOUT_RST = 16'd3;
  localparam logic [3:0]  RETRY_RST   = 4'd3;
  localparam logic [7:0]  LEN_RST     = 8'd255;

  // request commands
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  // status codes
  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_OK       = 2'd1,
    ST_ERR      = 2'd2,
    ST_GAVE_UP  = 2'd3
  } status_t;

  // result kinds
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // link modes
  localparam logic MODE_TX = 1'b0;

  // register indexes
  typedef enum logic [1:0] {
    REG_MODE    = 2'd0,
    REG_TIMEOUT = 2'd1,
    REG_RETRY   = 2'd2,
    REG_LEN     = 2'd3
  } reg_idx_t;

  // link phases
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_TX_WAIT = 2'd1,
    PH_RX_WAIT = 2'd2
  } phase_t;

  // configuration seen by the controller
  typedef struct packed {
    logic        link_mode;
    logic [15:0] timeout_ticks;
    logic [3:0]  retry_limit;
    logic [7:0]  frame_length_limit;
  } cfg_t;

  // result run produced by one request
  typedef struct packed {
    logic    has_status;
    status_t status;
    logic    has_frame;
    logic    frame_ua;
  } run_t;

endpackage

`default_nettype wire

FILE: rtl/lsh_ctrl.sv
// ----------------------------------------------------------------------------
// lsh_ctrl
// Link phase, frame gatherer, retry timer; builds the result run per request.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               fire,
  input  wire  [1:0]        cmd,
  input  wire  [7:0]        rx_byte,
  input  lsh_pkg::cfg_t     cfg,
  output logic              run_valid,
  output lsh_pkg::run_t     run
);
  import lsh_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [7:0]  previous_byte, previous_byte_next;
  logic [7:0]  address_byte, address_byte_next;
  logic [7:0]  control_byte, control_byte_next;
  logic [7:0]  check_byte, check_byte_next;
  logic [3:0]  retry_count, retry_count_next;
  logic [15:0] ticks_left, ticks_left_next;

  logic        in_frame;
  logic        closes;
  logic        check_ok;
  logic        expired;
  logic        give_up;

  // frame gatherer decisions
  always_comb begin
    in_frame = (phase == PH_TX_WAIT) || (phase == PH_RX_WAIT);
    closes   = ((byte_count > 8'd1) && (previous_byte != FLAG_BYTE) && (rx_byte == FLAG_BYTE))
               || (byte_count == cfg.frame_length_limit);
    expired  = (ticks_left <= 16'd1);
    give_up  = retry_count >= cfg.retry_limit;
  end

  // header bytes as they stand after this byte
  always_comb begin
    address_byte_next = address_byte;
    control_byte_next = control_byte;
    check_byte_next   = check_byte;
    if (byte_count == 8'd1) begin
      address_byte_next = rx_byte;
    end else if (byte_count == 8'd2) begin
      control_byte_next = rx_byte;
    end else if (byte_count == 8'd3) begin
      check_byte_next = rx_byte;
    end
    check_ok = (address_byte_next ^ control_byte_next) == check_byte_next;
  end

  // next state
  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    previous_byte_next = previous_byte;
    retry_count_next   = retry_count;
    ticks_left_next    = ticks_left;
    case (cmd)
      CMD_START: begin
        byte_count_next    = '0;
        previous_byte_next = '0;
        retry_count_next   = '0;
        if (cfg.link_mode == MODE_TX) begin
          ticks_left_next = cfg.timeout_ticks;
          phase_next      = PH_TX_WAIT;
        end else begin
          ticks_left_next = '0;
          phase_next      = PH_RX_WAIT;
        end
      end
      CMD_BYTE: begin
        if (in_frame) begin
          previous_byte_next = rx_byte;
          byte_count_next    = byte_count + 8'd1;
          if (closes) begin
            byte_count_next    = '0;
            previous_byte_next = '0;
            ticks_left_next    = '0;
            phase_next         = PH_IDLE;
          end
        end
      end
      CMD_TICK: begin
        if (phase == PH_TX_WAIT) begin
          if (!expired) begin
            ticks_left_next = ticks_left - 16'd1;
          end else if (give_up) begin
            ticks_left_next = '0;
            phase_next      = PH_IDLE;
          end else begin
            ticks_left_next  = cfg.timeout_ticks;
            retry_count_next = retry_count + 4'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // result run for this request
  always_comb begin
    run       = '{has_status: 1'b0, status: ST_NONE, has_frame: 1'b0, frame_ua: 1'b0};
    case (cmd)
      CMD_START: begin
        run.has_frame = cfg.link_mode == MODE_TX;
      end
      CMD_BYTE: begin
        if (in_frame && closes) begin
          run.has_status = 1'b1;
          run.status     = check_ok ? ST_OK : ST_ERR;
          run.has_frame  = phase == PH_RX_WAIT;
          run.frame_ua   = 1'b1;
        end
      end
      CMD_TICK: begin
        if ((phase == PH_TX_WAIT) && expired) begin
          run.has_status = give_up;
          run.status     = ST_GAVE_UP;
          run.has_frame  = !give_up;
        end
      end
      default: ;
    endcase
    run_valid = run.has_status || run.has_frame;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_count    <= '0;
      previous_byte <= '0;
      address_byte  <= '0;
      control_byte  <= '0;
      check_byte    <= '0;
      retry_count   <= '0;
      ticks_left    <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      previous_byte <= previous_byte_next;
      retry_count   <= retry_count_next;
      ticks_left    <= ticks_left_next;
      // header registers clear on start and on frame close
      if ((cmd == CMD_START) || ((cmd == CMD_BYTE) && in_frame && closes)) begin
        address_byte <= '0;
        control_byte <= '0;
        check_byte   <= '0;
      end else if ((cmd == CMD_BYTE) && in_frame) begin
        address_byte <= address_byte_next;
        control_byte <= control_byte_next;
        check_byte   <= check_byte_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lsh_tx_seq.sv
// ----------------------------------------------------------------------------
// lsh_tx_seq
// Holds one result run and hands its results out one per cycle while they are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_tx_seq (
  input  wire               clk,
  input  wire               rst,
  input  wire               load,
  input  lsh_pkg::run_t     run_in,
  output logic              busy,
  output logic              last,
  input  wire               take,
  output logic              result_kind,
  output logic [7:0]        tx_byte,
  output logic [1:0]        status_code
);
  import lsh_pkg::*;

  run_t       run;
  logic [2:0] idx;
  logic [2:0] total;
  logic [2:0] frame_pos;
  logic [7:0] addr;
  logic [7:0] ctrl;
  logic       at_status;

  // position within the run
  always_comb begin
    total     = (run.has_frame ? FRAME_LEN : 3'd0) + {2'd0, run.has_status};
    last      = idx == (total - 3'd1);
    at_status = run.has_status && (idx == 3'd0);
    frame_pos = idx - {2'd0, run.has_status};
    addr      = run.frame_ua ? ADDR_UA : ADDR_SET;
    ctrl      = run.frame_ua ? CTRL_UA : CTRL_SET;
  end

  // result fields
  always_comb begin
    result_kind = KIND_BYTE;
    status_code = ST_NONE;
    tx_byte     = '0;
    if (at_status) begin
      result_kind = KIND_STATUS;
      status_code = run.status;
    end else begin
      case (frame_pos)
        3'd1:    tx_byte = addr;
        3'd2:    tx_byte = ctrl;
        3'd3:    tx_byte = addr ^ ctrl;
        default: tx_byte = FLAG_BYTE;
      endcase
    end
  end

  // run register and index
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (take) begin
        if (last) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + 3'd1;
        end
      end
      if (load) begin
        busy <= 1'b1;
        idx  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run <= run_in;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/link_setup_handshake.sv
// ----------------------------------------------------------------------------
// link_setup_handshake
// One side of a SET/UA link setup: sends SET with timed resends, gathers
// received frames, checks the header and, as receiver, answers each frame with UA.
// ----------------------------------------------------------------------------
// latency: the first result of a request is shown the cycle after it is taken
// throughput: one request per cycle while no results are pending; a request
//   with n results (up to six) is followed by those n results, and the next
//   request is taken in the cycle the last of them is taken
// reset: synchronous rst returns registers to 0/3/3/255 and the link to idle
`default_nettype none

module link_setup_handshake (
  input  wire         clk,
  input  wire         rst,
  // configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  cmd,
  input  wire  [7:0]  rx_byte,
  // result channel
  output logic        out_valid,
  input  wire         out_ready,
  output logic        result_kind,
  output logic [7:0]  tx_byte,
  output logic [1:0]  status_code,
  output logic        last_of_run
);
  import lsh_pkg::*;

  cfg_t     cfg;
  reg_idx_t reg_sel;
  logic     cfg_write;
  logic     in_fire;
  logic     out_fire;
  logic     run_valid;
  run_t     run;
  logic     busy;
  logic     last;

  // register file
  always_comb begin
    reg_sel   = reg_idx_t'(paddr[3:2]);
    cfg_write = psel && penable && pwrite;
    pready    = 1'b1;
    case (reg_sel)
      REG_MODE:    prdata = {31'd0, cfg.link_mode};
      REG_TIMEOUT: prdata = {16'd0, cfg.timeout_ticks};
      REG_RETRY:   prdata = {28'd0, cfg.retry_limit};
      REG_LEN:     prdata = {24'd0, cfg.frame_length_limit};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.link_mode          <= MODE_TX;
      cfg.timeout_ticks      <= TIMEOUT_RST;
      cfg.retry_limit        <= RETRY_RST;
      cfg.frame_length_limit <= LEN_RST;
    end else if (cfg_write) begin
      case (reg_sel)
        REG_MODE:    cfg.link_mode          <= pwdata[0];
        REG_TIMEOUT: cfg.timeout_ticks      <= pwdata[15:0];
        REG_RETRY:   cfg.retry_limit        <= pwdata[3:0];
        REG_LEN:     cfg.frame_length_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // handshakes
  always_comb begin
    out_valid   = busy;
    last_of_run = last;
    out_fire    = out_valid && out_ready;
    in_ready    = !busy || (out_ready && last);
    in_fire     = in_valid && in_ready;
  end

  // protocol control
  lsh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (in_fire),
    .cmd       (cmd),
    .rx_byte   (rx_byte),
    .cfg       (cfg),
    .run_valid (run_valid),
    .run       (run)
  );

  // result sequencer
  lsh_tx_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .load        (in_fire && run_valid),
    .run_in      (run),
    .busy        (busy),
    .last        (last),
    .take        (out_fire),
    .result_kind (result_kind),
    .tx_byte     (tx_byte),
    .status_code (status_code)
  );

endmodule

`default_nettype wire

FILE: rtl/lsh_checker.sv
// ----------------------------------------------------------------------------
// lsh_checker
// Port-level checks of the link setup block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lsh_checker (
  input wire       clk,
  input wire       rst,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire       result_kind,
  input wire [7:0] tx_byte,
  input wire [1:0] status_code,
  input wire       last_of_run
);
  import lsh_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(status_code)
      && $stable(result_kind) && $stable(last_of_run))
    else $error("stalled result changed");

  // requests only back up behind pending results
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // byte results carry no status
  a_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_BYTE) |-> status_code == ST_NONE)
    else $error("byte result with status");

  // status reports carry a code and no byte
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_STATUS) |-> (status_code != ST_NONE) && (tx_byte == 8'd0))
    else $error("malformed status report");

  // giving up ends the run
  a_gave_up: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == KIND_STATUS) && (status_code == ST_GAVE_UP) |-> last_of_run)
    else $error("gave-up report not last");

endmodule

bind link_setup_handshake lsh_checker u_lsh_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .result_kind (result_kind),
  .tx_byte     (tx_byte),
  .status_code (status_code),
  .last_of_run (last_of_run)
);

`default_nettype wire

FILE: tb/tb_link_setup_handshake.sv
// ----------------------------------------------------------------------------
// tb_link_setup_handshake
// Self-checking bench for the SET/UA link setup block. Directed exchanges
// cover resends, giving up, short and overlong frames and the UA answer;
// random sessions follow under random stalls on both channels. Every result
// is checked against an in-bench model of the link kept in step with the
// accepted requests.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_link_setup_handshake;
  import lsh_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 250;
  localparam logic [1:0]  CMD_UNUSED    = 2'd3;

  // one result as the block shows it
  typedef struct packed {
    logic       kind;
    logic [7:0] tx;
    status_t    code;
    logic       last;
  } link_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  cmd = CMD_START;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        result_kind;
  logic [7:0]  tx_byte;
  logic [1:0]  status_code;
  logic        last_of_run;

  link_setup_handshake u_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .cmd         (cmd),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .tx_byte     (tx_byte),
    .status_code (status_code),
    .last_of_run (last_of_run)
  );

  always #5 clk = ~clk;

  // bench copy of the registers
  logic        cfg_mode    = MODE_TX;
  logic [15:0] cfg_timeout = TIMEOUT_RST;
  logic [3:0]  cfg_retry   = RETRY_RST;
  logic [7:0]  cfg_len     = LEN_RST;

  // bench copy of the link state
  phase_t      link_state   = PH_IDLE;
  logic [7:0]  frame_count  = '0;
  logic [7:0]  frame_prev   = '0;
  logic [7:0]  frame_addr   = '0;
  logic [7:0]  frame_ctrl   = '0;
  logic [7:0]  frame_check  = '0;
  logic [3:0]  resend_count = '0;
  logic [15:0] ticks_left   = '0;

  link_result_t expected_results[$];
  link_result_t pending_run[$];

  int unsigned sent_count;
  int unsigned results_checked;
  int unsigned reg_writes;
  int unsigned failures;
  int unsigned hold_requests;
  int unsigned holds_served;
  int unsigned stall_left;
  bit          calm;

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void report_field(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
      failures++;
    end
  endfunction

  // ---------------------------------------------------------------- model

  function automatic void clear_frame();
    frame_count = '0;
    frame_prev  = '0;
    frame_addr  = '0;
    frame_ctrl  = '0;
    frame_check = '0;
  endfunction

  function automatic void queue_frame(input logic [7:0] a, input logic [7:0] c);
    pending_run.push_back('{KIND_BYTE, FLAG_BYTE, ST_NONE, 1'b0});
    pending_run.push_back('{KIND_BYTE, a, ST_NONE, 1'b0});
    pending_run.push_back('{KIND_BYTE, c, ST_NONE, 1'b0});
    pending_run.push_back('{KIND_BYTE, a ^ c, ST_NONE, 1'b0});
    pending_run.push_back('{KIND_BYTE, FLAG_BYTE, ST_NONE, 1'b0});
  endfunction

  // results caused by one accepted request
  function automatic void predict_link(input logic [1:0] c, input logic [7:0] b);
    logic    closes;
    status_t code;
    pending_run.delete();
    case (c)
      CMD_START: begin
        clear_frame();
        resend_count = '0;
        if (cfg_mode == MODE_TX) begin
          queue_frame(ADDR_SET, CTRL_SET);
          ticks_left = cfg_timeout;
          link_state = PH_TX_WAIT;
        end else begin
          ticks_left = '0;
          link_state = PH_RX_WAIT;
        end
      end
      CMD_BYTE: begin
        if (link_state == PH_TX_WAIT || link_state == PH_RX_WAIT) begin
          closes = (frame_count > 8'd1 && frame_prev != FLAG_BYTE && b == FLAG_BYTE)
                   || frame_count == cfg_len;
          if (frame_count == 8'd1) frame_addr = b;
          else if (frame_count == 8'd2) frame_ctrl = b;
          else if (frame_count == 8'd3) frame_check = b;
          frame_prev  = b;
          frame_count = frame_count + 8'd1;
          if (closes) begin
            code = ((frame_addr ^ frame_ctrl) == frame_check) ? ST_OK : ST_ERR;
            pending_run.push_back('{KIND_STATUS, 8'h00, code, 1'b0});
            // the receiver answers with UA even on a bad header
            if (link_state == PH_RX_WAIT) queue_frame(ADDR_UA, CTRL_UA);
            clear_frame();
            ticks_left = '0;
            link_state = PH_IDLE;
          end
        end
      end
      CMD_TICK: begin
        if (link_state == PH_TX_WAIT) begin
          if (ticks_left > 16'd1) begin
            ticks_left = ticks_left - 16'd1;
          end else if (resend_count >= cfg_retry) begin
            pending_run.push_back('{KIND_STATUS, 8'h00, ST_GAVE_UP, 1'b0});
            ticks_left = '0;
            link_state = PH_IDLE;
          end else begin
            queue_frame(ADDR_SET, CTRL_SET);
            ticks_left   = cfg_timeout;
            resend_count = resend_count + 4'd1;
          end
        end
      end
      default: ;
    endcase
    if (pending_run.size() != 0) pending_run[pending_run.size() - 1].last = 1'b1;
    foreach (pending_run[i]) expected_results.push_back(pending_run[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_result();
    link_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result kind %0h tx %0h status %0h last %0h", $time,
               result_kind, tx_byte, status_code, last_of_run);
      failures++;
    end else begin
      want = expected_results.pop_front();
      report_field("result_kind", 32'(want.kind), 32'(result_kind));
      report_field("tx_byte", 32'(want.tx), 32'(tx_byte));
      report_field("status_code", 32'(want.code), 32'(status_code));
      report_field("last_of_run", 32'(want.last), 32'(last_of_run));
    end
    results_checked++;
  endfunction

  // check results first: a request taken at this edge shows nothing before the next
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result();
    if (!rst && in_valid && in_ready) predict_link(cmd, rx_byte);
  end

  // result side stalls, plus a long hold-off when a test asks for one
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      stall_left   <= LONG_HOLD;
      out_ready    <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("link_setup_handshake: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------- drivers

  // offer one request, optionally after a gap, and wait until it is taken
  task automatic send_request(input logic [1:0] c, input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_frame(input logic [7:0] a, input logic [7:0] c, input logic [7:0] chk);
    send_request(CMD_BYTE, FLAG_BYTE);
    send_request(CMD_BYTE, a);
    send_request(CMD_BYTE, c);
    send_request(CMD_BYTE, chk);
    send_request(CMD_BYTE, FLAG_BYTE);
  endtask

  // drain all results, then give the block time to finish silent requests
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write followed by a read back of the same register
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] stored;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_MODE: begin
        cfg_mode = value[0];
        stored   = 32'(value[0]);
      end
      REG_TIMEOUT: begin
        cfg_timeout = value[15:0];
        stored      = 32'(value[15:0]);
      end
      REG_RETRY: begin
        cfg_retry = value[3:0];
        stored    = 32'(value[3:0]);
      end
      default: begin
        cfg_len = value[7:0];
        stored  = 32'(value[7:0]);
      end
    endcase
    reg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    report_field("register read back", stored, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // random settings, extremes included now and then
  task automatic randomize_config();
    logic [15:0] tmo;
    logic [3:0]  rty;
    logic [7:0]  len;
    case ($urandom_range(0, 9))
      0:       tmo = 16'hFFFF;
      1:       tmo = 16'd1;
      default: tmo = 16'($urandom_range(1, 4));
    endcase
    case ($urandom_range(0, 9))
      0:       rty = 4'd15;
      1:       rty = 4'd0;
      default: rty = 4'($urandom_range(0, 3));
    endcase
    case ($urandom_range(0, 9))
      0:       len = 8'd255;
      1:       len = 8'd5;
      default: len = 8'($urandom_range(5, 12));
    endcase
    write_reg(REG_MODE, 32'($urandom_range(0, 1)));
    write_reg(REG_TIMEOUT, 32'(tmo));
    write_reg(REG_RETRY, 32'(rty));
    write_reg(REG_LEN, 32'(len));
  endtask

  // exchanges with random content: start, optional ticks and noise, then a frame or unused request
  task automatic run_session(input int unsigned budget);
    int unsigned stop_at;
    int unsigned n;
    logic [7:0]  a;
    logic [7:0]  c;
    logic [7:0]  chk;
    stop_at = sent_count + budget;
    while (sent_count < stop_at) begin
      send_request(CMD_START, rand_byte());
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 10);
        repeat (n) send_request(CMD_TICK, rand_byte());
      end
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n)
          send_request(CMD_BYTE, ($urandom_range(0, 3) == 0) ? FLAG_BYTE : rand_byte());
      end
      case ($urandom_range(0, 7))
        0: begin
          // short frame
          send_request(CMD_BYTE, FLAG_BYTE);
          send_request(CMD_BYTE, rand_byte());
          send_request(CMD_BYTE, FLAG_BYTE);
        end
        1: begin
          // no closing flag, runs into the length limit when that is 12 or less
          n = (cfg_len <= 8'd12) ? int'(cfg_len) + 1 : 8;
          repeat (n) send_request(CMD_BYTE, {1'b1, 7'($urandom_range(0, 127))});
        end
        2: send_request(CMD_UNUSED, rand_byte());
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            a = rand_byte();
            c = rand_byte();
          end else if (cfg_mode == MODE_TX) begin
            a = ADDR_UA;
            c = CTRL_UA;
          end else begin
            a = ADDR_SET;
            c = CTRL_SET;
          end
          chk = ($urandom_range(0, 3) == 0) ? rand_byte() : a ^ c;
          send_frame(a, c, chk);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- tests

  // reset settings: ignored requests, SET, a resend, then a good UA
  task automatic test_transmitter_basics();
    send_request(CMD_BYTE, FLAG_BYTE);
    send_request(CMD_TICK, 8'hFF);
    send_request(CMD_UNUSED, 8'h00);
    send_request(CMD_START, 8'h00);
    repeat (3) send_request(CMD_TICK, 8'h00);
    send_frame(ADDR_UA, CTRL_UA, ADDR_UA ^ CTRL_UA);
  endtask

  // zero timeout acts as one tick; no resends allowed; restart mid-frame
  task automatic test_give_up();
    wait_idle();
    write_reg(REG_TIMEOUT, 32'd0);
    write_reg(REG_RETRY, 32'd0);
    send_request(CMD_START, 8'h00);
    send_request(CMD_TICK, 8'h00);
    send_request(CMD_START, 8'h00);
    send_request(CMD_BYTE, FLAG_BYTE);
    send_request(CMD_START, 8'h00);
    send_request(CMD_TICK, 8'h00);
  endtask

  // receiver: SET answered by UA, short frame, lowered limit, length close
  task automatic test_receiver_frames();
    wait_idle();
    write_reg(REG_MODE, 32'd1);
    send_request(CMD_START, 8'h00);
    send_frame(ADDR_SET, CTRL_SET, ADDR_SET ^ CTRL_SET);
    send_request(CMD_START, 8'h00);
    send_request(CMD_BYTE, FLAG_BYTE);
    send_request(CMD_BYTE, 8'h05);
    send_request(CMD_BYTE, FLAG_BYTE);
    // limit lowered below the bytes already gathered, closed by a flag
    send_request(CMD_START, 8'h00);
    send_request(CMD_BYTE, 8'h11);
    send_request(CMD_BYTE, 8'h22);
    send_request(CMD_BYTE, 8'h33);
    send_request(CMD_BYTE, 8'h44);
    send_request(CMD_BYTE, 8'h55);
    send_request(CMD_BYTE, 8'h66);
    wait_idle();
    write_reg(REG_LEN, 32'd5);
    send_request(CMD_BYTE, FLAG_BYTE);
    // frame closed by the length limit
    send_request(CMD_START, 8'h00);
    send_request(CMD_BYTE, FLAG_BYTE);
    send_request(CMD_BYTE, 8'h00);
    send_request(CMD_BYTE, 8'hFF);
    send_request(CMD_BYTE, 8'hFF);
    send_request(CMD_BYTE, 8'h00);
    send_request(CMD_BYTE, 8'h5A);
  endtask

  task automatic test_random_sessions(input int unsigned count);
    int unsigned stop_at;
    stop_at = sent_count + count;
    while (sent_count < stop_at) begin
      wait_idle();
      randomize_config();
      run_session($urandom_range(15, 30));
    end
  endtask

  // result side held off while starts keep coming, so the input stalls
  task automatic test_backpressure();
    wait_idle();
    write_reg(REG_MODE, 32'(MODE_TX));
    hold_requests++;
    repeat (12) send_request(CMD_START, rand_byte());
  endtask

  // closing stretch with no idling on either side
  task automatic test_calm_tail();
    wait_idle();
    calm = 1'b1;
    randomize_config();
    run_session(30);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_transmitter_basics();
    test_give_up();
    test_receiver_frames();
    test_random_sessions(160);
    test_backpressure();
    test_calm_tail();
    wait_idle();
    $display("run covered %0d requests and %0d results in both link modes,", sent_count,
             results_checked);
    $display("with %0d register writes, resends, give-ups and length-limited frames",
             reg_writes);
    if (failures == 0) begin
      $display("link_setup_handshake: match");
    end else begin
      $display("link_setup_handshake: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/lsh_pkg.sv
rtl/lsh_ctrl.sv
rtl/lsh_tx_seq.sv
rtl/link_setup_handshake.sv
rtl/lsh_checker.sv
tb/tb_link_setup_handshake.sv
